FILE: hdl/scba_pkg.sv
// scba_pkg: shared constants of the size class bitmap allocator
`timescale 1ns / 1ps
package scba_pkg;

  localparam int REGION_BYTES_DEFAULT = 1048576;

  // used-map words per class, packed into one memory
  localparam int SMALL_WORDS   = 2048;
  localparam int SIXTEEN_WORDS = 1024;
  localparam int PAGE_WORDS    = 4;
  localparam int LARGE_WORDS   = 1;
  localparam int MAP_DEPTH     = SMALL_WORDS + SIXTEEN_WORDS + PAGE_WORDS + LARGE_WORDS;
  localparam int MAP_AW        = $clog2(MAP_DEPTH);

  localparam logic [MAP_AW-1:0] BASE_SMALL   = MAP_AW'(0);
  localparam logic [MAP_AW-1:0] BASE_SIXTEEN = MAP_AW'(SMALL_WORDS);
  localparam logic [MAP_AW-1:0] BASE_PAGE    = MAP_AW'(SMALL_WORDS + SIXTEEN_WORDS);
  localparam logic [MAP_AW-1:0] BASE_LARGE   = MAP_AW'(SMALL_WORDS + SIXTEEN_WORDS + PAGE_WORDS);

  // log2 of chunk sizes 8, 16, 4096, 16384
  localparam int SHIFT_SMALL   = 3;
  localparam int SHIFT_SIXTEEN = 4;
  localparam int SHIFT_PAGE    = 12;
  localparam int SHIFT_LARGE   = 14;

  localparam logic [1:0] CLASS_SMALL   = 2'd0;
  localparam logic [1:0] CLASS_SIXTEEN = 2'd1;
  localparam logic [1:0] CLASS_PAGE    = 2'd2;
  localparam logic [1:0] CLASS_LARGE   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NULL      = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_OUTSIDE   = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [0:0] ADDR_REGION_BASE = 1'b0;
  localparam logic [31:0] REGION_BASE_RESET = 32'h2001_0000;

endpackage

FILE: hdl/size_class_bitmap_allocator.sv
// size_class_bitmap_allocator: four-class bitmap allocator with a shared scan unit
`timescale 1ns / 1ps
// After reset the block sweeps its used-map memory to zero, one word a cycle, and
// holds busy high meanwhile. An allocate picks its class, steps past each full
// class, then reads and checks one used-map word after another (states S_RD and
// S_CHK), since one memory read port and one compare unit step through the map
// one 64-bit word at a time; a free locates its class, then reads and updates
// its word. Quick rejects (zero size, null address, size too big) finish
// straight from the idle state. Each result appears for one cycle with done
// high and cannot be stalled; a new transaction is taken whenever busy is low.
module size_class_bitmap_allocator #(
  parameter int REGION_BYTES = scba_pkg::REGION_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] request_size,
  input  logic [31:0] release_address,
  output logic        done,
  output logic [31:0] granted_address,
  output logic [2:0]  status,
  output logic [1:0]  size_class,
  output logic [17:0] free_left,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = scba_pkg::MAP_AW;

  localparam int CAP0 = REGION_BYTES >> scba_pkg::SHIFT_SMALL;
  localparam int CAP1 = REGION_BYTES >> scba_pkg::SHIFT_SIXTEEN;
  localparam int CAP2 = REGION_BYTES >> scba_pkg::SHIFT_PAGE;
  localparam int CAP3 = REGION_BYTES >> scba_pkg::SHIFT_LARGE;

  // offsets of each class's first chunk from region_base
  localparam int OFF0 = CAP0 / 8;
  localparam int OFF1 = OFF0 + CAP0 * 8 + CAP1 / 8;
  localparam int OFF2 = OFF1 + CAP1 * 16 + CAP2 / 8;
  localparam int OFF3 = OFF2 + CAP2 * 4096 + CAP3 / 8;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ALLOC, S_FIND, S_RD, S_CHK
  } state_t;

  state_t      state;
  logic [AW-1:0] clr;
  logic        op_q;
  logic [31:0] addr_q;
  logic [1:0]  cls;
  logic [10:0] word;
  logic [5:0]  bitpos;
  logic [17:0] cnt [4];
  logic [31:0] region_base;

  logic [63:0] map_mem [scba_pkg::MAP_DEPTH];
  logic [63:0] rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic [AW-1:0] raddr;

  // per-class selection
  logic [17:0]   cap_sel;
  logic [31:0]   off_sel;
  logic [31:0]   lim_sel;
  logic [3:0]    shift_sel;
  logic [AW-1:0] mbase_sel;
  logic [31:0]   fc;
  logic [31:0]   rel_off;
  logic [31:0]   rel_idx;
  logic [10:0]   last_word;
  logic [5:0]    rem;
  logic [63:0]   masked;
  logic [5:0]    lz;
  logic [16:0]   new_idx;
  logic [31:0]   grant;

  always_comb begin
    case (cls)
      scba_pkg::CLASS_SMALL: begin
        cap_sel = 18'(CAP0); off_sel = 32'(OFF0); lim_sel = 32'(CAP0 * 8);
        shift_sel = 4'(scba_pkg::SHIFT_SMALL); mbase_sel = scba_pkg::BASE_SMALL;
      end
      scba_pkg::CLASS_SIXTEEN: begin
        cap_sel = 18'(CAP1); off_sel = 32'(OFF1); lim_sel = 32'(CAP1 * 16);
        shift_sel = 4'(scba_pkg::SHIFT_SIXTEEN); mbase_sel = scba_pkg::BASE_SIXTEEN;
      end
      scba_pkg::CLASS_PAGE: begin
        cap_sel = 18'(CAP2); off_sel = 32'(OFF2); lim_sel = 32'(CAP2 * 4096);
        shift_sel = 4'(scba_pkg::SHIFT_PAGE); mbase_sel = scba_pkg::BASE_PAGE;
      end
      default: begin
        cap_sel = 18'(CAP3); off_sel = 32'(OFF3); lim_sel = 32'(CAP3 * 16384);
        shift_sel = 4'(scba_pkg::SHIFT_LARGE); mbase_sel = scba_pkg::BASE_LARGE;
      end
    endcase
  end

  assign fc        = region_base + off_sel;
  assign rel_off   = addr_q - fc;
  assign rel_idx   = rel_off >> shift_sel;
  assign last_word = 11'((cap_sel - 18'd1) >> 6);
  assign rem       = cap_sel[5:0];

  // bits past the class capacity count as used
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      masked[b] = rdata[b] | ((word == last_word) && (rem != 6'd0) && (6'(b) >= rem));
    end
  end

  always_comb begin
    lz = 6'd0;
    for (int b = 63; b >= 0; b--) begin
      if (!masked[b]) lz = 6'(b);
    end
  end

  assign new_idx = {word, lz};
  assign grant   = fc + ({15'd0, new_idx} << shift_sel);
  assign raddr   = mbase_sel + AW'(word);
  assign busy    = (state != S_IDLE);
  assign pready  = 1'b1;
  assign prdata  = (paddr == scba_pkg::ADDR_REGION_BASE) ? region_base : 32'd0;

  always_comb begin
    we    = 1'b0;
    waddr = raddr;
    wdata = rdata;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr;
      wdata = 64'd0;
    end else if (state == S_CHK) begin
      if (op_q == scba_pkg::OP_ALLOC) begin
        we    = ~&masked;
        wdata = rdata | (64'd1 << lz);
      end else begin
        we    = rdata[bitpos];
        wdata = rdata & ~(64'd1 << bitpos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) map_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= map_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= scba_pkg::REGION_BASE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == scba_pkg::ADDR_REGION_BASE) begin
      region_base <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      clr    <= '0;
      done   <= 1'b0;
      cnt[0] <= 18'(CAP0);
      cnt[1] <= 18'(CAP1);
      cnt[2] <= 18'(CAP2);
      cnt[3] <= 18'(CAP3);
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(scba_pkg::MAP_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          granted_address <= 32'd0;
          size_class      <= 2'd0;
          free_left       <= 18'd0;
          if (start) begin
            op_q   <= op;
            addr_q <= release_address;
            if (op == scba_pkg::OP_ALLOC) begin
              if (request_size == 32'd0) begin
                done <= 1'b1; status <= scba_pkg::ST_NULL;
              end else if (request_size > 32'd16384) begin
                done <= 1'b1; status <= scba_pkg::ST_NO_SPACE;
              end else begin
                if (request_size <= 32'd8) cls <= scba_pkg::CLASS_SMALL;
                else if (request_size <= 32'd16) cls <= scba_pkg::CLASS_SIXTEEN;
                else if (request_size <= 32'd4096) cls <= scba_pkg::CLASS_PAGE;
                else cls <= scba_pkg::CLASS_LARGE;
                state <= S_ALLOC;
              end
            end else if (release_address == 32'd0) begin
              done <= 1'b1; status <= scba_pkg::ST_NULL;
            end else begin
              cls   <= scba_pkg::CLASS_SMALL;
              state <= S_FIND;
            end
          end
        end
        S_ALLOC: begin
          if (cnt[cls] == 18'd0) begin
            if (cls == scba_pkg::CLASS_LARGE) begin
              done <= 1'b1; status <= scba_pkg::ST_NO_SPACE; state <= S_IDLE;
            end else begin
              cls <= cls + 2'd1;
            end
          end else begin
            word  <= 11'd0;
            state <= S_RD;
          end
        end
        S_FIND: begin
          if (rel_off < lim_sel) begin
            word   <= rel_idx[16:6];
            bitpos <= rel_idx[5:0];
            state  <= S_RD;
          end else if (cls == scba_pkg::CLASS_LARGE) begin
            done <= 1'b1; status <= scba_pkg::ST_OUTSIDE; state <= S_IDLE;
          end else begin
            cls <= cls + 2'd1;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (op_q == scba_pkg::OP_ALLOC) begin
            if (&masked) begin
              word  <= word + 11'd1;
              state <= S_RD;
            end else begin
              cnt[cls]        <= cnt[cls] - 18'd1;
              done            <= 1'b1;
              status          <= scba_pkg::ST_OK;
              granted_address <= grant;
              size_class      <= cls;
              free_left       <= cnt[cls] - 18'd1;
              state           <= S_IDLE;
            end
          end else begin
            done       <= 1'b1;
            size_class <= cls;
            state      <= S_IDLE;
            if (rdata[bitpos]) begin
              cnt[cls]  <= cnt[cls] + 18'd1;
              status    <= scba_pkg::ST_OK;
              free_left <= cnt[cls] + 18'd1;
            end else begin
              status    <= scba_pkg::ST_NOT_ALLOC;
              free_left <= cnt[cls];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= scba_pkg::ST_NOT_ALLOC)
    else $error("status code out of range");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    done && status != scba_pkg::ST_OK |-> granted_address == 32'd0)
    else $error("address granted on failed transaction");

  a_no_class_fields: assert property (@(posedge clk) disable iff (rst)
    done && (status == scba_pkg::ST_NULL || status == scba_pkg::ST_NO_SPACE ||
             status == scba_pkg::ST_OUTSIDE) |-> size_class == 2'd0 && free_left == 18'd0)
    else $error("class fields set without a class");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= 18'(CAP0) && cnt[1] <= 18'(CAP1) && cnt[2] <= 18'(CAP2) && cnt[3] <= 18'(CAP3))
    else $error("free count above capacity");

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for the size class bitmap allocator
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [2:0]  status;
    logic [1:0]  size_class;
    logic [17:0] free_left;
  } alloc_result_t;

  typedef struct {
    int unsigned cls;
    int unsigned idx;
  } chunk_ref_t;

  localparam logic [31:0] BASE_HIGH = 32'd4290748376;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [31:0] request_size;
  logic [31:0] release_address;
  logic        done;
  logic [31:0] granted_address;
  logic [2:0]  status;
  logic [1:0]  size_class;
  logic [17:0] free_left;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  size_class_bitmap_allocator dut (.*);

  // allocator image kept by the bench
  logic [31:0]  region_base_q;
  logic [63:0]  used_bits [4][2048];
  int unsigned  free_cnt [4];
  int unsigned  chunk_sz [4] = '{8, 16, 4096, 16384};
  int unsigned  map_len  [4] = '{2048, 1024, 4, 1};

  alloc_result_t expected_results [$];
  chunk_ref_t    live_chunks [$];
  int            errors;
  int            burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned class_cap(int unsigned c);
    return map_len[c] * 64;
  endfunction

  function automatic logic [31:0] chunk_area_start(int unsigned c);
    logic [31:0] b;
    b = region_base_q;
    for (int k = 0; k < c; k++) b += class_cap(k) / 8 + class_cap(k) * chunk_sz[k];
    return b + class_cap(c) / 8;
  endfunction

  function automatic int lowest_free(int unsigned c);
    for (int w = 0; w < map_len[c]; w++) begin
      if (used_bits[c][w] != '1) begin
        for (int b = 0; b < 64; b++) if (!used_bits[c][w][b]) return w * 64 + b;
      end
    end
    return -1;
  endfunction

  function automatic void drop_live(int unsigned c, int unsigned i);
    foreach (live_chunks[k]) begin
      if (live_chunks[k].cls == c && live_chunks[k].idx == i) begin
        live_chunks.delete(k);
        return;
      end
    end
  endfunction

  function automatic alloc_result_t predict_transaction(logic o, logic [31:0] sz,
                                                        logic [31:0] addr);
    alloc_result_t r;
    logic [31:0] off;
    int          idx;
    int unsigned i;
    r = '0;
    if (o == scba_pkg::OP_ALLOC) begin
      if (sz == 0) begin
        r.status = scba_pkg::ST_NULL;
      end else begin
        r.status = scba_pkg::ST_NO_SPACE;
        for (int c = 0; c < 4; c++) begin
          if (sz > chunk_sz[c]) continue;
          idx = lowest_free(c);
          if (idx >= 0) begin
            used_bits[c][idx / 64][idx % 64] = 1'b1;
            free_cnt[c]--;
            r.granted_address = chunk_area_start(c) + idx * chunk_sz[c];
            r.status = scba_pkg::ST_OK;
            r.size_class = c;
            r.free_left = free_cnt[c];
            live_chunks.push_back('{c, idx});
            break;
          end
        end
      end
    end else if (addr == 0) begin
      r.status = scba_pkg::ST_NULL;
    end else begin
      r.status = scba_pkg::ST_OUTSIDE;
      for (int c = 0; c < 4; c++) begin
        off = addr - chunk_area_start(c);
        if (off < class_cap(c) * chunk_sz[c]) begin
          i = off / chunk_sz[c];
          r.size_class = c;
          if (!used_bits[c][i / 64][i % 64]) begin
            r.status = scba_pkg::ST_NOT_ALLOC;
          end else begin
            used_bits[c][i / 64][i % 64] = 1'b0;
            free_cnt[c]++;
            r.status = scba_pkg::ST_OK;
            drop_live(c, i);
          end
          r.free_left = free_cnt[c];
          break;
        end
      end
    end
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic o, logic [31:0] sz, logic [31:0] addr);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    start = 1'b1;
    op = o;
    request_size = sz;
    release_address = addr;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_transaction(o, sz, addr));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_region_base(logic [31:0] value);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = scba_pkg::ADDR_REGION_BASE;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    region_base_q = value;
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned r, c;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 10) return $urandom();
    if (r < 13) return $urandom_range(16385, 32'hFFFF_FFFF);
    c = $urandom_range(0, 3);
    return (c == 0) ? $urandom_range(1, 8) : $urandom_range(chunk_sz[c - 1] + 1, chunk_sz[c]);
  endfunction

  function automatic logic [31:0] pick_address();
    int unsigned r, c, k;
    chunk_ref_t  ch;
    r = $urandom_range(0, 99);
    if (r < 55 && live_chunks.size() != 0) begin
      k = $urandom_range(0, live_chunks.size() - 1);
      ch = live_chunks[k];
      return chunk_area_start(ch.cls) + ch.idx * chunk_sz[ch.cls]
             + $urandom_range(0, chunk_sz[ch.cls] - 1);
    end
    if (r < 75) begin
      c = $urandom_range(0, 3);
      return chunk_area_start(c) + $urandom_range(0, 127) * chunk_sz[c];
    end
    if (r < 82) return 0;
    return $urandom();
  endfunction

  task automatic run_random_mix(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 45) send_item(scba_pkg::OP_FREE, $urandom(), pick_address());
      else send_item(scba_pkg::OP_ALLOC, pick_size(), $urandom());
    end
  endtask

  task automatic test_register_reset();
    while (busy) @(negedge clk);
    psel = 1'b1;
    paddr = scba_pkg::ADDR_REGION_BASE;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== scba_pkg::REGION_BASE_RESET) begin
      $error("region_base read: expected %h actual %h", scba_pkg::REGION_BASE_RESET, prdata);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_directed_cases();
    send_item(scba_pkg::OP_ALLOC, 0, 0);
    send_item(scba_pkg::OP_ALLOC, 1, 0);
    send_item(scba_pkg::OP_ALLOC, 8, 0);
    send_item(scba_pkg::OP_ALLOC, 9, 0);
    send_item(scba_pkg::OP_ALLOC, 16, 0);
    send_item(scba_pkg::OP_ALLOC, 17, 0);
    send_item(scba_pkg::OP_ALLOC, 4096, 0);
    send_item(scba_pkg::OP_ALLOC, 4097, 0);
    send_item(scba_pkg::OP_ALLOC, 16384, 0);
    send_item(scba_pkg::OP_ALLOC, 16385, 0);
    send_item(scba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(scba_pkg::OP_FREE, 32'hFFFF_FFFF, 0);
    // misaligned free, then the same chunk again
    send_item(scba_pkg::OP_FREE, 0, chunk_area_start(scba_pkg::CLASS_SMALL) + 3);
    send_item(scba_pkg::OP_FREE, 0, chunk_area_start(scba_pkg::CLASS_SMALL));
    send_item(scba_pkg::OP_FREE, 0, region_base_q);
    send_item(scba_pkg::OP_FREE, 0, 32'hFFFF_FFFF);
    send_item(scba_pkg::OP_FREE, 0,
              chunk_area_start(scba_pkg::CLASS_LARGE) + 64 * 16384 - 1);
    send_item(scba_pkg::OP_FREE, 0, chunk_area_start(scba_pkg::CLASS_LARGE) + 64 * 16384);
    send_item(scba_pkg::OP_FREE, 0, chunk_area_start(scba_pkg::CLASS_SIXTEEN));
    send_item(scba_pkg::OP_FREE, 0, chunk_area_start(scba_pkg::CLASS_PAGE) + 4096);
    send_item(scba_pkg::OP_FREE, 0, chunk_area_start(scba_pkg::CLASS_PAGE) - 1);
  endtask

  // page class fills and spills into the large class until both are full, then frees and a page allocate follow
  task automatic test_page_fallback();
    while (free_cnt[scba_pkg::CLASS_PAGE] != 0 || free_cnt[scba_pkg::CLASS_LARGE] != 0)
      send_item(scba_pkg::OP_ALLOC, $urandom_range(17, 4096), $urandom());
    repeat (3) send_item(scba_pkg::OP_ALLOC, $urandom_range(17, 16384), $urandom());
    wait_drained();
    repeat (40) send_item(scba_pkg::OP_FREE, $urandom(), pick_address());
    send_item(scba_pkg::OP_ALLOC, 4000, 0);
  endtask

  task automatic test_region_base_sweep();
    write_region_base(32'd0);
    run_random_mix(70);
    write_region_base(BASE_HIGH);
    run_random_mix(70);
    write_region_base($urandom_range(0, BASE_HIGH));
    run_random_mix(70);
    write_region_base(scba_pkg::REGION_BASE_RESET);
    run_random_mix(70);
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (granted_address !== exp_r.granted_address) begin
          $error("granted_address: expected %h actual %h", exp_r.granted_address,
                 granted_address);
          errors++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, status);
          errors++;
        end
        if (size_class !== exp_r.size_class) begin
          $error("size_class: expected %0d actual %0d", exp_r.size_class, size_class);
          errors++;
        end
        if (free_left !== exp_r.free_left) begin
          $error("free_left: expected %0d actual %0d", exp_r.free_left, free_left);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = scba_pkg::OP_ALLOC;
    request_size = '0;
    release_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = scba_pkg::ADDR_REGION_BASE;
    pwdata = '0;
    errors = 0;
    burst_left = 0;
    region_base_q = scba_pkg::REGION_BASE_RESET;
    for (int c = 0; c < 4; c++) begin
      free_cnt[c] = class_cap(c);
      for (int w = 0; w < 2048; w++) used_bits[c][w] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_reset();
    test_directed_cases();
    test_page_fallback();
    test_region_base_sweep();

    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: size_class_bitmap_allocator.f
hdl/scba_pkg.sv
hdl/size_class_bitmap_allocator.sv
bench/testbench.sv
